>>> rtl/core/utf16le_to_utf8_transcoder_defines.svh
// Assertion helpers shared by the transcoder RTL.
`ifndef UTF16LE_TO_UTF8_TRANSCODER_DEFINES_SVH
`define UTF16LE_TO_UTF8_TRANSCODER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define U16U8_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("u16u8 same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define U16U8_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("u16u8 next-cycle check failed");

`endif

>>> rtl/core/u16u8_pkg.sv
package u16u8_pkg;

    // Most bytes one code unit can produce: a U+FFFD for a broken pair plus
    // one three-byte BMP character.
    localparam int RUN_MAX = 6;
    localparam int CNT_W   = 3;

    localparam logic [15:0] HIGH_FIRST  = 16'hD800;
    localparam logic [15:0] HIGH_LAST   = 16'hDBFF;
    localparam logic [15:0] LOW_FIRST   = 16'hDC00;
    localparam logic [15:0] LOW_LAST    = 16'hDFFF;
    localparam logic [15:0] REPLACEMENT = 16'hFFFD;
    localparam logic [20:0] SUPP_BASE   = 21'h10000;

    localparam logic [7:0] LEAD2 = 8'hC0;
    localparam logic [7:0] LEAD3 = 8'hE0;
    localparam logic [7:0] LEAD4 = 8'hF0;
    localparam logic [7:0] CONT  = 8'h80;

    typedef logic [7:0] byte_t;

    // Bytes caused by one code unit, in send order from index 0.
    typedef struct packed {
        byte_t [RUN_MAX-1:0] bytes;
        logic  [CNT_W-1:0]   count;
    } run_t;

endpackage

>>> rtl/core/utf16le_to_utf8_transcoder.sv
// UTF-16 code units in, UTF-8 bytes out.
// Input channel (s_valid/s_ready): one 16-bit code unit per word plus
// s_last_unit marking the final unit of a stream. Output channel
// (m_valid/m_ready): one byte per word; m_last_of_run marks the final byte
// produced by one input unit. Units that produce no bytes (a held high
// surrogate, a zero unit) are taken without any output word.
// The first byte of a unit is on m_out_byte in the cycle after the unit is
// accepted. A unit producing N bytes is sent as N words through the single
// output byte port; the next unit is taken in the cycle its predecessor's
// last byte leaves, so units of one byte or less flow at one per cycle
// while m_ready stays high.
// When the receiver stalls, the current byte holds and s_ready stays low
// until the last byte of the run is being taken.
// A high surrogate that is the last unit of a stream is not held but is
// encoded on its own, so nothing is held across streams. Synchronous
// active-low reset empties the output and drops any held surrogate.
module utf16le_to_utf8_transcoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_code_unit,
    input  logic        s_last_unit,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_last_of_run
);
    import u16u8_pkg::*;

    run_t run;
    logic accept;
    logic can_load;

    assign s_ready = can_load;
    assign accept  = s_valid && can_load;

    // Surrogate handling and byte encoding for the incoming word
    u16u8_encoder u_encoder (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .code_unit (s_code_unit),
        .last_unit (s_last_unit),
        .run       (run)
    );

    // Holds the encoded run and hands it out one byte per word
    u16u8_byte_queue u_queue (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (accept),
        .run           (run),
        .can_load      (can_load),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_last_of_run (m_last_of_run)
    );

endmodule

>>> rtl/core/u16u8_encoder.sv
module u16u8_encoder (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               accept,
    input  logic [15:0]        code_unit,
    input  logic               last_unit,
    output u16u8_pkg::run_t    run
);
    import u16u8_pkg::*;

    typedef struct packed {
        byte_t [2:0] b;
        logic  [1:0] len;
    } bmp_enc_t;

    // UTF-8 for a code point of the basic plane; zero gives no bytes.
    function automatic bmp_enc_t enc_bmp(input logic [15:0] cp);
        bmp_enc_t e;
        e.b   = '0;
        e.len = 2'd0;
        if (cp == 16'h0000) begin
            e.len = 2'd0;
        end else if (cp <= 16'h007F) begin
            e.b[0] = cp[7:0];
            e.len  = 2'd1;
        end else if (cp <= 16'h07FF) begin
            e.b[0] = LEAD2 | {3'b000, cp[10:6]};
            e.b[1] = CONT | {2'b00, cp[5:0]};
            e.len  = 2'd2;
        end else begin
            e.b[0] = LEAD3 | {4'h0, cp[15:12]};
            e.b[1] = CONT | {2'b00, cp[11:6]};
            e.b[2] = CONT | {2'b00, cp[5:0]};
            e.len  = 2'd3;
        end
        return e;
    endfunction

    logic        high_pending_reg, high_pending_next;
    logic [9:0]  held_high_reg, held_high_next;

    logic        is_high, is_low, pair;
    logic [15:0] second_cp;
    logic [20:0] supp_cp;
    bmp_enc_t    second_enc, repl_enc;

    assign is_high = (code_unit >= HIGH_FIRST) && (code_unit <= HIGH_LAST);
    assign is_low  = (code_unit >= LOW_FIRST) && (code_unit <= LOW_LAST);
    assign pair    = high_pending_reg && is_low;

    // Supplementary code point from the held high and this low surrogate
    assign supp_cp = SUPP_BASE + {1'b0, held_high_reg, code_unit[9:0]};

    // Unit handled on its own; a high that is held gives nothing yet
    assign second_cp  = is_low ? REPLACEMENT : code_unit;
    assign repl_enc   = enc_bmp(REPLACEMENT);

    always_comb begin
        second_enc = enc_bmp(second_cp);
        if (is_high && !last_unit) begin
            second_enc.len = 2'd0;
        end
    end

    // Assemble the run of bytes for this unit
    always_comb begin
        run.bytes = '0;
        run.count = '0;
        if (pair) begin
            run.bytes[0] = LEAD4 | {5'b00000, supp_cp[20:18]};
            run.bytes[1] = CONT | {2'b00, supp_cp[17:12]};
            run.bytes[2] = CONT | {2'b00, supp_cp[11:6]};
            run.bytes[3] = CONT | {2'b00, supp_cp[5:0]};
            run.count    = CNT_W'(4);
        end else if (high_pending_reg) begin
            for (int i = 0; i < 3; i++) begin
                run.bytes[i]     = repl_enc.b[i];
                run.bytes[i + 3] = second_enc.b[i];
            end
            run.count = CNT_W'(3) + CNT_W'(second_enc.len);
        end else begin
            for (int i = 0; i < 3; i++) begin
                run.bytes[i] = second_enc.b[i];
            end
            run.count = CNT_W'(second_enc.len);
        end
    end

    // Surrogate hold state, updated per accepted word
    always_comb begin
        high_pending_next = high_pending_reg;
        held_high_next    = held_high_reg;
        if (accept) begin
            high_pending_next = is_high && !last_unit;
            if (is_high && !last_unit) begin
                held_high_next = code_unit[9:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            high_pending_reg <= 1'b0;
            held_high_reg    <= '0;
        end else begin
            high_pending_reg <= high_pending_next;
            held_high_reg    <= held_high_next;
        end
    end

endmodule

>>> rtl/core/u16u8_byte_queue.sv
`include "utf16le_to_utf8_transcoder_defines.svh"

module u16u8_byte_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  u16u8_pkg::run_t    run,
    output logic               can_load,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_out_byte,
    output logic               m_last_of_run
);
    import u16u8_pkg::*;

    byte_t [RUN_MAX-1:0] bytes_reg, bytes_next;
    logic  [CNT_W-1:0]   cnt_reg, cnt_next;
    logic                pop;

    assign m_valid       = (cnt_reg != '0);
    assign pop           = m_valid && m_ready;
    assign can_load      = (cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && m_ready);
    assign m_out_byte    = bytes_reg[0];
    assign m_last_of_run = (cnt_reg == CNT_W'(1));

    // Load a new run once the old one drains, else shift out one word per pop
    always_comb begin
        bytes_next = bytes_reg;
        cnt_next   = cnt_reg;
        if (load) begin
            bytes_next = run.bytes;
            cnt_next   = run.count;
        end else if (pop) begin
            for (int i = 0; i < RUN_MAX - 1; i++) begin
                bytes_next[i] = bytes_reg[i + 1];
            end
            bytes_next[RUN_MAX-1] = '0;
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        bytes_reg <= bytes_next;
    end

    `U16U8_ASSERT_IMPL(a_load_when_free, aclk, aresetn, load,
        (cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && pop))
    `U16U8_ASSERT_NEXT(a_pop_counts_down, aclk, aresetn, pop && !load,
        cnt_reg == $past(cnt_reg) - CNT_W'(1))
    `U16U8_ASSERT_IMPL(a_count_in_range, aclk, aresetn, 1'b1,
        cnt_reg <= CNT_W'(RUN_MAX))
    `U16U8_ASSERT_NEXT(a_load_takes_run, aclk, aresetn, load,
        cnt_reg == $past(run.count))

endmodule
